// File: rtl/assert_macros.svh
// Assertion macros used by the core RTL file of the span remap table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge while reset is released.
`define SCRT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Checks that a condition never holds while reset is released.
`define SCRT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/scrt_pkg.sv
// Types and constants of the span compaction remap table.
package scrt_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned CAP_W           = 7;
  localparam int unsigned CFG_IDX_W       = 8;
  localparam int unsigned TABLE_DEPTH_DEF = 64;

  localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
  localparam logic [WORD_W-1:0] PACK_MAX  = 32'hFFFF_FFFF;

  // Operation codes carried in the func field.
  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LENGTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY_LIMIT = 8'd1;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] old_offset;
    logic [WORD_W-1:0] span_length;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] new_offset;
    logic [WORD_W-1:0] packed_length;
    logic              identity;
  } out_item_t;

endpackage

// File: rtl/scrt_ram.sv
// Generic single-port-write, registered-read RAM.
module scrt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/span_compaction_remap_table_core.sv
// Top level of the span compaction remap table: sequencer, scan compare and table RAM.
//
// Usage. An item (func, old_offset, span_length) is taken at a rising edge where
// start is high and busy is low. busy then stays high until the item's single
// result has been produced. An add appends a non-empty span at the current packed
// length when it fits the source pool, is not a duplicate, the table has room and
// the packed length does not overflow. A lookup returns the packed offset of an
// exactly matching span.
// Results appear on out_data for exactly one cycle with out_valid high; the
// receiver cannot stall, so it must take every item as it appears.
// Sequence. A range check, then a scan over the stored entries at one entry per
// cycle through the RAM's single read port and the shared comparator; a match
// ends it early. The last registered read is compared, the scan closes and the
// result is registered. Empty spans and adds outside the source pool skip the
// scan. The next item can be taken at the end of the result cycle.
// Configuration. cfg_ready is always high; register writes land at once and
// are meant to be issued while the block is idle. Unknown indexes are ignored.
// Reset. rst_n clears the entry count and packed length, sets the kept-offsets flag and
// loads the register defaults; the table RAM is not cleared since entries at or
// above the entry count are never compared.
module span_compaction_remap_table_core #(
  parameter int unsigned TABLE_DEPTH = scrt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  scrt_pkg::in_item_t                      in_data,
  output logic                                    out_valid,
  output scrt_pkg::out_item_t                     out_data,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [scrt_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [scrt_pkg::WORD_W-1:0]             cfg_data
);

  import scrt_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CAPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned RAMW = 3 * WORD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          item_r;
  logic [WORD_W-1:0] src_len_r;
  logic [CAP_W-1:0]  cap_lim_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [WORD_W-1:0] packed_r, packed_nxt;
  logic              kept_r, kept_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic              out_valid_r;
  out_item_t         out_r, out_nxt;

  // Table RAM: each word holds {old offset, length, packed offset}.
  logic              ram_we;
  logic [RAMW-1:0]   ram_wdata;
  logic [RAMW-1:0]   ram_rdata;
  logic [WORD_W-1:0] rd_old, rd_len, rd_new;

  logic [CAPW-1:0]   cap_ext, eff_cap;
  logic              table_full, would_ovf, in_source;
  logic              more_entries, key_hit, issue, scan_end;
  logic              fin, res_ok;
  logic [WORD_W-1:0] res_off;

  scrt_ram #(
    .WIDTH (RAMW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign ram_wdata = {item_r.old_offset, item_r.span_length, packed_r};
  assign rd_old    = ram_rdata[3*WORD_W-1:2*WORD_W];
  assign rd_len    = ram_rdata[2*WORD_W-1:WORD_W];
  assign rd_new    = ram_rdata[WORD_W-1:0];

  // Capacity is the configured limit saturated to the table depth.
  assign cap_ext    = CAPW'(cap_lim_r);
  assign eff_cap    = (cap_ext > CAPW'(TABLE_DEPTH)) ? CAPW'(TABLE_DEPTH) : cap_ext;
  assign table_full = (CAPW'(count_r) >= eff_cap);

  // The packed length overflows when the span exceeds the room left below all ones.
  assign would_ovf = (item_r.span_length > (PACK_MAX - packed_r));

  // A span fits the source when it is empty or lies wholly inside it.
  assign in_source = (item_r.span_length == '0) ||
                     ((item_r.old_offset <= src_len_r) &&
                      (item_r.span_length <= (src_len_r - item_r.old_offset)));

  // The shared comparator checks one stored entry per cycle against the key.
  assign more_entries = (rd_idx_r < count_r);
  assign key_hit  = (state_r == ST_SCAN) && cmp_vld_r &&
                    (rd_old == item_r.old_offset) && (rd_len == item_r.span_length);
  assign issue    = (state_r == ST_SCAN) && more_entries && !key_hit;
  assign scan_end = (state_r == ST_SCAN) && !key_hit && !cmp_vld_r && !more_entries;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    packed_nxt  = packed_r;
    kept_nxt    = kept_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = 1'b0;
    ram_we      = 1'b0;
    fin         = 1'b0;
    res_ok      = 1'b0;
    res_off     = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        rd_idx_nxt = '0;
        if ((item_r.func == FUNC_ADD) && !in_source) begin
          fin = 1'b1;
        end else if (item_r.span_length == '0) begin
          fin    = 1'b1;
          res_ok = 1'b1;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx_nxt  = rd_idx_r + 1'b1;
          cmp_vld_nxt = 1'b1;
        end
        if (key_hit) begin
          fin    = 1'b1;
          res_ok = 1'b1;
          if (item_r.func == FUNC_LOOKUP) begin
            res_off = rd_new;
          end
        end else if (scan_end) begin
          fin = 1'b1;
          if ((item_r.func == FUNC_ADD) && !table_full && !would_ovf) begin
            // New span goes at the current end of the packed pool.
            ram_we     = 1'b1;
            res_ok     = 1'b1;
            count_nxt  = count_r + 1'b1;
            packed_nxt = packed_r + item_r.span_length;
            kept_nxt   = kept_r && (item_r.old_offset == packed_r);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = ST_IDLE;
    end

    out_nxt.ok            = res_ok;
    out_nxt.new_offset    = res_off;
    out_nxt.packed_length = packed_nxt;
    out_nxt.identity      = kept_nxt && (packed_nxt == src_len_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      item_r      <= '0;
      src_len_r   <= '0;
      cap_lim_r   <= CAP_RESET;
      count_r     <= '0;
      packed_r    <= '0;
      kept_r      <= 1'b1;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      packed_r    <= packed_nxt;
      kept_r      <= kept_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= fin;
      if (fin) begin
        out_r <= out_nxt;
      end
      if ((state_r == ST_IDLE) && start) begin
        item_r <= in_data;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_SOURCE_LENGTH:  src_len_r <= cfg_data;
          REG_CAPACITY_LIMIT: cap_lim_r <= cfg_data[CAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // An accepted item holds the block busy on the next cycle.
  `SCRT_ASSERT(a_start_busy, clk, rst_n, (start && !busy) |=> busy)
  // Every result is a single-cycle strobe.
  `SCRT_ASSERT(a_result_pulse, clk, rst_n, out_valid_r |=> !out_valid_r)
  // The entry count only ever grows by one.
  `SCRT_ASSERT(a_count_step, clk, rst_n,
    ($past(rst_n) && (count_r != $past(count_r))) |-> (count_r == $past(count_r) + 1'b1))
  // The entry count never passes the table depth.
  `SCRT_NEVER(a_count_max, clk, rst_n, (count_r > CW'(TABLE_DEPTH)))

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the span compaction remap table core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scrt_pkg::*;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

  // An index past the register list. Writes to it must leave both registers alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  span_compaction_remap_table_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's registers and table. The predictor updates it as
  // each item is accepted, so it always reflects the block after that item.
  logic [WORD_W-1:0] src_len_q;
  logic [CAP_W-1:0]  cap_q;
  logic [WORD_W-1:0] tbl_old [DEPTH];
  logic [WORD_W-1:0] tbl_len [DEPTH];
  logic [WORD_W-1:0] tbl_new [DEPTH];
  int unsigned       n_entries;
  logic [WORD_W-1:0] packed_q;
  bit                kept_q;

  // Results the block still owes, oldest first. Only one item is ever in flight,
  // but a new item may be accepted on the edge that delivers the previous result.
  out_item_t   span_results_due[$];
  int unsigned failures;

  // Percentage of cycles in which the sender holds off before offering an item.
  int unsigned sender_gap_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run. A correct run needs roughly a tenth of this.
  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  // Searches the stored spans for an exact match on offset and length.
  function automatic bit find_entry(input logic [WORD_W-1:0] off,
                                    input logic [WORD_W-1:0] len,
                                    output int unsigned slot);
    slot = 0;
    for (int unsigned i = 0; i < n_entries && i < DEPTH; i++) begin
      if (tbl_old[i] == off && tbl_len[i] == len) begin
        slot = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Works out the result of one add or lookup and applies its effect on the
  // shadow state.
  function automatic out_item_t predict_span_op(input in_item_t it);
    out_item_t         r;
    int unsigned       slot;
    int unsigned       cap;
    bit                in_src;
    r = '0;
    cap = (cap_q > DEPTH) ? DEPTH : cap_q;
    if (it.func == FUNC_ADD) begin
      // An empty span always fits; otherwise it must end inside the source pool.
      in_src = (it.span_length == '0) ||
               (it.old_offset <= src_len_q &&
                it.span_length <= src_len_q - it.old_offset);
      if (!in_src) begin
        r.ok = 1'b0;
      end else if (it.span_length == '0 || find_entry(it.old_offset, it.span_length, slot)) begin
        r.ok = 1'b1;
      end else if (n_entries >= cap || it.span_length > PACK_MAX - packed_q) begin
        r.ok = 1'b0;
      end else begin
        tbl_old[n_entries] = it.old_offset;
        tbl_len[n_entries] = it.span_length;
        tbl_new[n_entries] = packed_q;
        if (it.old_offset != packed_q) kept_q = 1'b0;
        n_entries++;
        packed_q = packed_q + it.span_length;
        r.ok = 1'b1;
      end
    end else begin
      if (it.span_length == '0) begin
        r.ok = 1'b1;
      end else if (find_entry(it.old_offset, it.span_length, slot)) begin
        r.ok = 1'b1;
        r.new_offset = tbl_new[slot];
      end
    end
    r.packed_length = packed_q;
    r.identity = kept_q && (packed_q == src_len_q);
    return r;
  endfunction

  // Builds one random item. Half of them are shaped after the table's current
  // contents, so that hits, duplicates and near misses are frequent; the rest
  // are fresh spans inside the source pool, empty spans and raw noise.
  function automatic in_item_t random_span_op();
    in_item_t          it;
    int unsigned       pick;
    int unsigned       k;
    logic [WORD_W-1:0] room;
    pick = $urandom_range(99);
    it.func = $urandom_range(1) ? FUNC_LOOKUP : FUNC_ADD;
    it.old_offset = $urandom;
    it.span_length = $urandom;
    k = (n_entries > 0) ? $urandom_range(n_entries - 1) : 0;
    if (pick < 30 && n_entries > 0) begin
      it.func = FUNC_LOOKUP;
      it.old_offset = tbl_old[k];
      it.span_length = tbl_len[k];
    end else if (pick < 42 && n_entries > 0) begin
      it.func = FUNC_ADD;
      it.old_offset = tbl_old[k];
      it.span_length = tbl_len[k];
    end else if (pick < 50 && n_entries > 0) begin
      // One field of a stored span nudged by one, so the match must be exact.
      it.old_offset = tbl_old[k];
      it.span_length = tbl_len[k];
      case ($urandom_range(3))
        0: it.old_offset = it.old_offset + 1;
        1: it.old_offset = it.old_offset - 1;
        2: it.span_length = it.span_length + 1;
        default: it.span_length = it.span_length - 1;
      endcase
    end else if (pick < 75) begin
      // Fresh span that fits the source pool; mostly short so the packed
      // length keeps room for more appends.
      it.func = ($urandom_range(4) == 0) ? FUNC_LOOKUP : FUNC_ADD;
      it.span_length = ($urandom_range(9) == 0) ? $urandom : $urandom_range(4096, 1);
      if (it.span_length > src_len_q) it.span_length = src_len_q;
      room = src_len_q - it.span_length;
      it.old_offset = $urandom_range(room);
    end else if (pick < 82) begin
      it.span_length = '0;
    end
    return it;
  endfunction

  // Offers one item and waits for the block to take it. start stays high from
  // one item to the next unless the sender decides to idle.
  task automatic issue_span_op(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    span_results_due.push_back(predict_span_op(it));
  endtask

  task automatic issue(input logic func, input logic [WORD_W-1:0] off,
                       input logic [WORD_W-1:0] len);
    in_item_t it;
    it.func = func;
    it.old_offset = off;
    it.span_length = len;
    issue_span_op(it);
  endtask

  // Stops offering items and waits until every owed result has arrived and the
  // block is no longer busy.
  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (span_results_due.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write, issued only once the block has gone idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [WORD_W-1:0] value);
    wait_results_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SOURCE_LENGTH:  src_len_q = value;
      REG_CAPACITY_LIMIT: cap_q = value[CAP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Compares one delivered result with the oldest owed one, field by field.
  task automatic check_span_result(input out_item_t got);
    out_item_t want;
    if (span_results_due.size() == 0) begin
      $error("result with nothing owed: ok=%0h new_offset=%0h packed_length=%0h identity=%0h",
             got.ok, got.new_offset, got.packed_length, got.identity);
      failures++;
    end else begin
      want = span_results_due.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0h, got %0h", want.ok, got.ok);
        failures++;
      end
      if (got.new_offset !== want.new_offset) begin
        $error("new_offset: expected %0h, got %0h", want.new_offset, got.new_offset);
        failures++;
      end
      if (got.packed_length !== want.packed_length) begin
        $error("packed_length: expected %0h, got %0h", want.packed_length, got.packed_length);
        failures++;
      end
      if (got.identity !== want.identity) begin
        $error("identity: expected %0h, got %0h", want.identity, got.identity);
        failures++;
      end
    end
  endtask

  // The receiver cannot stall: every strobe is a result that must be checked.
  always @(posedge clk) begin
    if (rst_n && out_valid) check_span_result(out_data);
  end

  // Register defaults: source length zero, so an empty add leaves the packed
  // length equal to the source and the identity flag must read one.
  task automatic test_reset_defaults();
    issue(FUNC_LOOKUP, 32'd0, 32'd0);
    issue(FUNC_LOOKUP, 32'd5, 32'd7);
    issue(FUNC_ADD, 32'd0, 32'd0);
    issue(FUNC_ADD, 32'd0, 32'd1);
  endtask

  // Spans added back to back from offset zero keep every offset; once they
  // cover the whole source the mapping is the identity.
  task automatic test_identity_packing();
    write_register(REG_SOURCE_LENGTH, 32'd100);
    issue(FUNC_ADD, 32'd0, 32'd40);
    issue(FUNC_ADD, 32'd40, 32'd60);
    issue(FUNC_LOOKUP, 32'd40, 32'd60);
  endtask

  // Spans starting past the source end, running past it, and an empty span
  // right at the end.
  task automatic test_source_bounds();
    issue(FUNC_ADD, 32'd101, 32'd1);
    issue(FUNC_ADD, 32'd50, 32'd51);
    issue(FUNC_ADD, 32'd100, 32'd0);
    issue(FUNC_ADD, 32'd100, 32'd1);
    issue(FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // A duplicate leaves everything as is; a new span at offset zero lands at
  // the packed end, which breaks the identity for good.
  task automatic test_duplicates_and_lookup();
    issue(FUNC_ADD, 32'd0, 32'd40);
    issue(FUNC_ADD, 32'd0, 32'd100);
    issue(FUNC_LOOKUP, 32'd0, 32'd100);
    issue(FUNC_LOOKUP, 32'd0, 32'd41);
    issue(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // A limit at or below the entry count blocks adds; a limit above the depth
  // saturates to the depth.
  task automatic test_capacity_limit();
    write_register(REG_CAPACITY_LIMIT, 32'd3);
    issue(FUNC_ADD, 32'd5, 32'd5);
    write_register(REG_CAPACITY_LIMIT, 32'd0);
    issue(FUNC_ADD, 32'd6, 32'd6);
    write_register(REG_CAPACITY_LIMIT, 32'd127);
    issue(FUNC_ADD, 32'd5, 32'd5);
  endtask

  // With the whole address range as source, large spans run the packed length
  // into its 32-bit ceiling.
  task automatic test_packed_overflow();
    write_register(REG_SOURCE_LENGTH, 32'hFFFF_FFFF);
    issue(FUNC_ADD, 32'd1, 32'h8000_0000);
    issue(FUNC_ADD, 32'd2, 32'h8000_0000);
    issue(FUNC_ADD, 32'd0, 32'hFFFF_FFFF);
  endtask

  // A write to an index past the list must not disturb either register.
  task automatic test_unknown_register();
    write_register(REG_UNUSED, 32'd5);
    issue(FUNC_ADD, 32'd3, 32'd3);
  endtask

  // One phase of random traffic under one register setting and one sender
  // idling rate. Halfway through, the sender pauses until all results are in.
  task automatic run_traffic_phase(input int unsigned gap_pct,
                                   input logic [WORD_W-1:0] src,
                                   input logic [WORD_W-1:0] cap,
                                   input int unsigned count);
    write_register(REG_SOURCE_LENGTH, src);
    write_register(REG_CAPACITY_LIMIT, cap);
    sender_gap_pct = gap_pct;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) wait_results_drained();
      issue_span_op(random_span_op());
    end
    sender_gap_pct = 0;
  endtask

  // The table is never cleared after reset, so the phases run in an order that
  // first grows it under a tight limit, then lets it fill, then mostly looks up.
  task automatic test_random_traffic();
    run_traffic_phase(0, 32'hFFFF_FFFF, 32'd40, 300);
    run_traffic_phase(49, 32'hFFFF_FFFF, 32'd127, 300);
    run_traffic_phase(0, $urandom, 32'd64, 300);
    run_traffic_phase(8, 32'd0, 32'd0, 300);
  endtask

  initial begin
    int unsigned guard;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failures = 0;
    sender_gap_pct = 0;
    src_len_q = '0;
    cap_q = CAP_RESET;
    n_entries = 0;
    packed_q = '0;
    kept_q = 1'b1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_identity_packing();
    test_source_bounds();
    test_duplicates_and_lookup();
    test_capacity_limit();
    test_packed_overflow();
    test_unknown_register();
    test_random_traffic();

    // Let the last results come in, bounded, then give the block a full scan's
    // worth of cycles to show any stray strobe.
    @(negedge clk);
    start <= 1'b0;
    guard = 0;
    while (span_results_due.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
    if (span_results_due.size() != 0) begin
      $error("%0d results never arrived", span_results_due.size());
      failures++;
    end

    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
